>>> hdl/mask_transition_blend_top_defines.svh
// Assertion macros shared by the mask transition blend RTL.
// Needs clk and arst_n in the scope of every module that expands them.
`ifndef MASK_TRANSITION_BLEND_TOP_DEFINES_SVH
`define MASK_TRANSITION_BLEND_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mtb_pkg.sv
// Shared widths, register codes and pipeline payload types of the mask blend.
// No dependencies.
`default_nettype none

package mtb_pkg;

	localparam int PIX_W     = 8;
	localparam int CHAN_N    = 3;
	localparam int TIME_W    = 11;
	localparam int RAMP_W    = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int NUM_W     = 18;
	localparam int PROD_W    = 2 * PIX_W;

	localparam logic [TIME_W-1:0] TIME_RESET = '0;
	localparam logic [RAMP_W-1:0] RAMP_RESET = 10'd51;
	localparam logic [PIX_W-1:0]  ALPHA_FULL = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP = 1'b1;

	typedef struct packed {
		logic [CHAN_N-1:0][PIX_W-1:0] chan_a;
		logic [CHAN_N-1:0][PIX_W-1:0] chan_b;
		logic                         frame_end;
	} pixel_t;

	typedef struct packed {
		logic below;
		logic above;
	} range_t;

	typedef struct packed {
		logic             below;
		logic             above;
		logic [PIX_W-1:0] quotient;
	} weight_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [1:0]       qbits;
	} div_t;

endpackage

`default_nettype wire

>>> hdl/mtb_alpha.sv
// Weight pipeline: range compare, numerator, then a four-stage radix-4 divider.
// Depends on mtb_pkg and mask_transition_blend_top_defines.svh.
`default_nettype none
`include "mask_transition_blend_top_defines.svh"

module mtb_alpha import mtb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire pixel_t            in_pix,
	input  wire logic [PIX_W-1:0]  in_mask,
	input  wire logic [TIME_W-1:0] time_pos,
	input  wire logic [RAMP_W-1:0] ramp_len,
	output logic                   out_valid,
	output pixel_t                 out_pix,
	output weight_t                out_weight
);

	// Two restoring steps of the quotient, bits sh+1 and sh.
	function automatic div_t div_step2(input logic [NUM_W-1:0] rem,
			input logic [RAMP_W-1:0] d, input int unsigned sh);
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] dsh;
		div_t             res;
		r = rem;
		res.qbits = '0;
		dsh = NUM_W'(d) << (sh + 1);
		if (r >= dsh) begin
			r = r - dsh;
			res.qbits[1] = 1'b1;
		end
		dsh = NUM_W'(d) << sh;
		if (r >= dsh) begin
			r = r - dsh;
			res.qbits[0] = 1'b1;
		end
		res.rem = r;
		return res;
	endfunction

	range_t            flags_c;
	logic [NUM_W-1:0]  num_c;
	logic [TIME_W-1:0] edge_end_c;
	logic [RAMP_W-1:0] diff_c;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	pixel_t            pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	range_t            flags_s1, flags_s2, flags_s3, flags_s4, flags_s5;
	logic [RAMP_W-1:0] d_s1, d_s2, d_s3, d_s4;
	logic [NUM_W-1:0]  rem_s1, rem_s2, rem_s3, rem_s4;
	logic [1:0]        q_s2;
	logic [3:0]        q_s3;
	logic [5:0]        q_s4;
	logic [PIX_W-1:0]  q_s5;
	div_t              st2_c, st3_c, st4_c, st5_c;

	// Inside the soft edge t - m is below the ramp length, so ten bits suffice.
	always_comb begin
		edge_end_c    = TIME_W'(in_mask) + TIME_W'(ramp_len);
		flags_c.below = time_pos < TIME_W'(in_mask);
		flags_c.above = time_pos >= edge_end_c;
		diff_c        = RAMP_W'(time_pos - TIME_W'(in_mask));
		num_c         = {diff_c, 8'b0} - NUM_W'(diff_c) + NUM_W'(ramp_len[RAMP_W-1:1]);
	end

	always_comb begin
		st2_c = div_step2(rem_s1, d_s1, 6);
		st3_c = div_step2(rem_s2, d_s2, 4);
		st4_c = div_step2(rem_s3, d_s3, 2);
		st5_c = div_step2(rem_s4, d_s4, 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= in_pix;
			flags_s1 <= flags_c;
			d_s1     <= ramp_len;
			rem_s1   <= num_c;

			pix_s2   <= pix_s1;
			flags_s2 <= flags_s1;
			d_s2     <= d_s1;
			rem_s2   <= st2_c.rem;
			q_s2     <= st2_c.qbits;

			pix_s3   <= pix_s2;
			flags_s3 <= flags_s2;
			d_s3     <= d_s2;
			rem_s3   <= st3_c.rem;
			q_s3     <= {q_s2, st3_c.qbits};

			pix_s4   <= pix_s3;
			flags_s4 <= flags_s3;
			d_s4     <= d_s3;
			rem_s4   <= st4_c.rem;
			q_s4     <= {q_s3, st4_c.qbits};

			pix_s5   <= pix_s4;
			flags_s5 <= flags_s4;
			q_s5     <= {q_s4, st5_c.qbits};
		end
	end

	assign out_valid           = valid_s5;
	assign out_pix             = pix_s5;
	assign out_weight.below    = flags_s5.below;
	assign out_weight.above    = flags_s5.above;
	assign out_weight.quotient = q_s5;

	`MTB_ASSERT_NEXT(a_load_s1, en && in_valid, valid_s1, "accepted pixel did not enter stage 1")
	`MTB_ASSERT_NOW(a_flags_excl, valid_s1, !(flags_s1.below && flags_s1.above),
		"pixel is both before and past the soft edge")
	`MTB_ASSERT_NEXT(a_stall_hold, !en && valid_s5, valid_s5, "stage 5 lost a pixel during a stall")

endmodule

`default_nettype wire

>>> hdl/mtb_blend.sv
// Blend pipeline: weight select and channel products, then the divide-by-255 rounding.
// Depends on mtb_pkg.
`default_nettype none

module mtb_blend import mtb_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire pixel_t                       in_pix,
	input  wire weight_t                      in_weight,
	output logic                              out_valid,
	output logic [CHAN_N-1:0][PIX_W-1:0]      out_chan,
	output logic                              out_frame_end
);

	logic [PIX_W-1:0]                 alpha_c;
	logic [PIX_W-1:0]                 beta_c;
	logic [CHAN_N-1:0][PROD_W-1:0]    pa_c, pb_c;
	logic [CHAN_N-1:0][PIX_W-1:0]     y_c;
	logic [PROD_W:0]                  v_c, r_c;

	logic                             valid_s6, valid_s7;
	logic [CHAN_N-1:0][PROD_W-1:0]    pa_s6, pb_s6;
	logic                             fe_s6, fe_s7;
	logic [CHAN_N-1:0][PIX_W-1:0]     y_s7;

	always_comb begin
		if (in_weight.below) begin
			alpha_c = '0;
		end else if (in_weight.above) begin
			alpha_c = ALPHA_FULL;
		end else begin
			alpha_c = in_weight.quotient;
		end
		beta_c = ALPHA_FULL - alpha_c;
		for (int i = 0; i < CHAN_N; i++) begin
			pa_c[i] = in_pix.chan_a[i] * alpha_c;
			pb_c[i] = in_pix.chan_b[i] * beta_c;
		end
	end

	// v / 255 approximated as ((v + 1) + (v >> 8)) >> 8.
	always_comb begin
		v_c = '0;
		r_c = '0;
		for (int i = 0; i < CHAN_N; i++) begin
			v_c     = {1'b0, pa_s6[i]} + {1'b0, pb_s6[i]};
			r_c     = v_c + (PROD_W+1)'(1) + (v_c >> 8);
			y_c[i]  = r_c[PROD_W-1:PIX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s6 <= in_valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s6 <= pa_c;
			pb_s6 <= pb_c;
			fe_s6 <= in_pix.frame_end;
			y_s7  <= y_c;
			fe_s7 <= fe_s6;
		end
	end

	assign out_valid     = valid_s7;
	assign out_chan      = y_s7;
	assign out_frame_end = fe_s7;

endmodule

`default_nettype wire

>>> hdl/mask_transition_blend_top.sv
// Top level of the mask-driven wipe between two YCbCr pictures.
// A pixel passes stages 1 to 7 in order; the divider retires two quotient bits per stage.
// Throughput: one pixel per clock while the output is not stalled.
// A stalled output freezes all seven stages together, so nothing is lost or repeated.
// Reset clears every stage valid bit, sets time_position to 0 and ramp_length to 51.
// Depends on mtb_pkg, mtb_alpha, mtb_blend and mask_transition_blend_top_defines.svh.
`default_nettype none
`include "mask_transition_blend_top_defines.svh"

module mask_transition_blend_top import mtb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Configuration write port; index 0 is time_position, index 1 is ramp_length.
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,

	// Pixel input stream.
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// Fields from bit 0 up: luma_a, chroma_b_a, chroma_r_a, mask_value,
	// luma_b, chroma_b_b, chroma_r_b.
	input  wire logic [55:0]          s_axis_tdata,
	// frame_end.
	input  wire logic                 s_axis_tlast,

	// Blended pixel output stream.
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// Fields from bit 0 up: luma_out, chroma_b_out, chroma_r_out.
	output logic [23:0]               m_axis_tdata,
	// frame_end_out.
	output logic                      m_axis_tlast
);

	logic [TIME_W-1:0]              time_q;
	logic [RAMP_W-1:0]              ramp_q;

	logic                           en;
	pixel_t                         in_pix;
	logic [PIX_W-1:0]               in_mask;

	logic                           mid_valid;
	pixel_t                         mid_pix;
	weight_t                        mid_weight;

	logic [CHAN_N-1:0][PIX_W-1:0]   out_chan;

	// Configuration registers. The user must change them only while the pipeline is
	// empty (not enforced here); the stages read them directly where they need them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= TIME_RESET;
			ramp_q <= RAMP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIME: begin
					time_q <= cfg_data;
				end
				CFG_RAMP: begin
					ramp_q <= cfg_data[RAMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline advances whenever the output register is empty or its
	// transaction completes in this cycle. Bubbles then drain naturally.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Unpack the input transaction.
	assign in_pix.chan_a[0]  = s_axis_tdata[7:0];
	assign in_pix.chan_a[1]  = s_axis_tdata[15:8];
	assign in_pix.chan_a[2]  = s_axis_tdata[23:16];
	assign in_mask           = s_axis_tdata[31:24];
	assign in_pix.chan_b[0]  = s_axis_tdata[39:32];
	assign in_pix.chan_b[1]  = s_axis_tdata[47:40];
	assign in_pix.chan_b[2]  = s_axis_tdata[55:48];
	assign in_pix.frame_end  = s_axis_tlast;

	// Stages 1 to 5: where the pixel sits on the soft edge, and its weight.
	mtb_alpha u_alpha (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.in_pix     (in_pix),
		.in_mask    (in_mask),
		.time_pos   (time_q),
		.ramp_len   (ramp_q),
		.out_valid  (mid_valid),
		.out_pix    (mid_pix),
		.out_weight (mid_weight)
	);

	// Stages 6 and 7: weighted channel sums and the rounding divide by 255.
	// Stage 7 is the output register.
	mtb_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (mid_valid),
		.in_pix        (mid_pix),
		.in_weight     (mid_weight),
		.out_valid     (m_axis_tvalid),
		.out_chan      (out_chan),
		.out_frame_end (m_axis_tlast)
	);

	assign m_axis_tdata = out_chan;

	`MTB_ASSERT_NOW(a_stall_only_full, !s_axis_tready, m_axis_tvalid,
		"input stalled while the output register is empty")

endmodule

`default_nettype wire
